/* hdl/http_chunked_body_decoder_top_assert.svh */
// assertion macros for the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define HCBD_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("hcbd assertion failed");

`define HCBD_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error("hcbd forbidden condition seen");

`else

`define HCBD_ASSERT(lbl, clk_sig, rst_n_sig, prop)

`define HCBD_ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond)

`endif

`endif

/* hdl/hcbd_pkg.sv */
// types, constants and helpers shared by the chunked body decoder
package hcbd_pkg;

	localparam int unsigned SIZE_BITS = 31;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [1:0] ST_ZERO     = 2'd0;
	localparam logic [1:0] ST_EARLY    = 2'd1;
	localparam logic [1:0] ST_NODIGIT  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [1:0] {
		PH_SIZE,
		PH_DATA,
		PH_SKIP,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       end_of_body;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       last;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       end_of_body;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} class_t;

	function automatic class_t classify(input in_item_t it);
		class_t c;
		c.body_byte   = it.body_byte;
		c.end_of_body = it.end_of_body;
		c.is_cr       = (it.body_byte == CHAR_CR);
		c.is_lf       = (it.body_byte == CHAR_LF);
		c.hex_ok      = 1'b1;
		c.hex_val     = 4'd0;
		if (it.body_byte inside {[8'h30:8'h39]}) begin
			c.hex_val = it.body_byte[3:0];
		end else if (it.body_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			c.hex_val = it.body_byte[3:0] + 4'd9;
		end else begin
			c.hex_ok = 1'b0;
		end
		return c;
	endfunction

endpackage

/* hdl/hcbd_front.sv */
// front end: byte classification and a two-entry queue towards the back end
module hcbd_front import hcbd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     q_pop,
	output logic     q_valid,
	output class_t   q_item
);

	class_t     ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= classify(item);
		end
	end

endmodule

/* hdl/hcbd_back.sv */
// back end: chunk framing state machine and a two-entry result queue
module hcbd_back import hcbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  class_t    q_item,
	output logic      q_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] size_q, size_n;
	logic [SIZE_BITS-1:0] remain_q, remain_n;
	logic                 digit_q, digit_n;
	logic                 closed_q, closed_n;
	logic                 cr_q, cr_n;
	logic                 skip_q, skip_n;
	logic                 take;
	logic                 emit;
	out_item_t            res;

	out_item_t  oq_q [2];
	logic       oq_wr_q;
	logic       oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic       oq_push;
	logic       oq_pop;

	assign take  = q_valid && (oq_cnt_q != 2'd2);
	assign q_pop = take;

	always_comb begin
		phase_n  = phase_q;
		size_n   = size_q;
		remain_n = remain_q;
		digit_n  = digit_q;
		closed_n = closed_q;
		cr_n     = cr_q;
		skip_n   = skip_q;
		emit     = 1'b0;
		res      = '0;
		case (phase_q)
			PH_SIZE: begin
				if (cr_q && q_item.is_lf) begin
					if (!digit_q) begin
						emit       = 1'b1;
						res.last   = 1'b1;
						res.status = ST_NODIGIT;
						phase_n    = PH_DRAIN;
					end else if (size_q == '0) begin
						emit       = 1'b1;
						res.last   = 1'b1;
						res.status = ST_ZERO;
						phase_n    = PH_DRAIN;
					end else begin
						remain_n = size_q;
						phase_n  = PH_DATA;
					end
					size_n   = '0;
					digit_n  = 1'b0;
					closed_n = 1'b0;
					cr_n     = 1'b0;
				end else begin
					cr_n = q_item.is_cr;
					if (q_item.hex_ok && !closed_q) begin
						if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
							emit       = 1'b1;
							res.last   = 1'b1;
							res.status = ST_OVERFLOW;
							phase_n    = PH_DRAIN;
							size_n     = '0;
							digit_n    = 1'b0;
							closed_n   = 1'b0;
							cr_n       = 1'b0;
						end else begin
							size_n  = {size_q[SIZE_BITS-5:0], q_item.hex_val};
							digit_n = 1'b1;
						end
					end else begin
						closed_n = 1'b1;
					end
				end
			end
			PH_DATA: begin
				emit           = 1'b1;
				res.data_valid = 1'b1;
				res.data_byte  = q_item.body_byte;
				remain_n       = remain_q - {{(SIZE_BITS-1){1'b0}}, 1'b1};
				if (remain_n == '0) begin
					phase_n = PH_SKIP;
					skip_n  = 1'b0;
				end
			end
			PH_SKIP: begin
				if (skip_q) begin
					phase_n  = PH_SIZE;
					skip_n   = 1'b0;
					size_n   = '0;
					digit_n  = 1'b0;
					closed_n = 1'b0;
					cr_n     = 1'b0;
				end else begin
					skip_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (q_item.end_of_body) begin
			if (!res.last && phase_n != PH_DRAIN) begin
				emit       = 1'b1;
				res.last   = 1'b1;
				res.status = ST_EARLY;
			end
			phase_n  = PH_SIZE;
			size_n   = '0;
			remain_n = '0;
			digit_n  = 1'b0;
			closed_n = 1'b0;
			cr_n     = 1'b0;
			skip_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			size_q   <= '0;
			remain_q <= '0;
			digit_q  <= 1'b0;
			closed_q <= 1'b0;
			cr_q     <= 1'b0;
			skip_q   <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_n;
			size_q   <= size_n;
			remain_q <= remain_n;
			digit_q  <= digit_n;
			closed_q <= closed_n;
			cr_q     <= cr_n;
			skip_q   <= skip_n;
		end
	end

	// result queue
	assign oq_push = take && emit;
	assign empty   = (oq_cnt_q == 2'd0);
	assign oq_pop  = pop && !empty;
	assign result  = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			case ({oq_push, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 2'd1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 2'd1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= res;
		end
	end

endmodule

/* hdl/http_chunked_body_decoder_top.sv */
// chunked body decoder: one body byte per cycle in while full is low, decoded bytes and end status out
// a byte is registered in the input queue, and its result in the result queue, before it reaches the result ports
// throughput: 1 byte per cycle unless the result queue is full, set by the framing step in the back end
// two-entry queues on the input side and the result side absorb stalls on either side
// reset (arst_n low) empties both queues and returns the framer to the size line
`include "http_chunked_body_decoder_top_assert.svh"

module http_chunked_body_decoder_top import hcbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic   q_valid;
	class_t q_item;
	logic   q_pop;

	hcbd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	hcbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	`HCBD_ASSERT_NEVER(a_pop_without_item, clk, arst_n, q_pop && !q_valid)
	`HCBD_ASSERT(a_bare_result_is_last, clk, arst_n, (!empty && !result.data_valid) |-> result.last)
	`HCBD_ASSERT(a_status_only_with_last, clk, arst_n, (!empty && !result.last) |-> (result.status == ST_ZERO))

endmodule

/* sim/testbench.sv */
// self-checking testbench for the chunked body decoder: directed table, random bodies, scoreboard
module testbench import hcbd_pkg::*; ();

	localparam int unsigned QUIET_LIMIT = 1000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned RANDOM_ITEMS = 1850;
	localparam logic [SIZE_BITS-1:0] SIZE_FULL = '1;

	typedef struct packed {
		in_item_t  it;
		logic      chk;
		logic      emits;
		out_item_t res;
		logic      hold;
	} feed_row_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eob;
		logic       chk;
		logic       emits;
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic [1:0] status;
	} table_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	http_chunked_body_decoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// decoder state mirrored by the predictor
	phase_t               line_phase = PH_SIZE;
	logic [SIZE_BITS-1:0] size_acc = '0;
	logic [SIZE_BITS-1:0] left = '0;
	logic                 digit_seen = 1'b0;
	logic                 digits_closed = 1'b0;
	logic                 cr_seen = 1'b0;
	logic [1:0]           skip_cnt = '0;

	feed_row_t   body_feed[$];
	out_item_t   pending_results[$];
	logic [7:0]  body_bytes[$];
	int unsigned row_idx = 0;
	int unsigned random_items = 0;
	int unsigned error_count = 0;
	int unsigned result_count = 0;
	int unsigned quiet = 0;
	bit          feed_done = 1'b0;
	bit          stall_req = 1'b0;

	table_row_t directed_rows [22] = '{
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_CR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_LF, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_ZERO},
		'{8'h00,   1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_CR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_LF, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_NODIGIT},
		'{8'hff,   1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"1",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_CR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_CR, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{CHAR_LF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{8'hff,   1'b1, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1, ST_EARLY},
		'{"8",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"0",     1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_OVERFLOW},
		'{"F",     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, '0},
		'{"a",     1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ST_EARLY}
	};

	function automatic void new_line();
		size_acc = '0;
		digit_seen = 1'b0;
		digits_closed = 1'b0;
		cr_seen = 1'b0;
	endfunction

	function automatic bit decode_step(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		logic [3:0] nib;
		bit         is_hex;
		bit         emit;
		bit         fin;
		logic [1:0] why;
		b = it.body_byte;
		emit = 1'b0;
		fin = 1'b0;
		why = '0;
		res = '0;
		case (line_phase)
			PH_SIZE: begin
				if (cr_seen && b == CHAR_LF) begin
					if (!digit_seen) begin
						emit = 1'b1;
						fin = 1'b1;
						why = ST_NODIGIT;
						line_phase = PH_DRAIN;
					end else if (size_acc == '0) begin
						emit = 1'b1;
						fin = 1'b1;
						why = ST_ZERO;
						line_phase = PH_DRAIN;
					end else begin
						left = size_acc;
						line_phase = PH_DATA;
					end
					new_line();
				end else begin
					is_hex = 1'b1;
					nib = '0;
					if (b >= "0" && b <= "9") nib = 4'(b - "0");
					else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
					else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
					else is_hex = 1'b0;
					cr_seen = (b == CHAR_CR);
					if (is_hex && !digits_closed) begin
						if (size_acc > (SIZE_FULL >> 4)) begin
							emit = 1'b1;
							fin = 1'b1;
							why = ST_OVERFLOW;
							line_phase = PH_DRAIN;
							new_line();
						end else begin
							size_acc = {size_acc[SIZE_BITS-5:0], nib};
							digit_seen = 1'b1;
						end
					end else begin
						digits_closed = 1'b1;
					end
				end
			end
			PH_DATA: begin
				emit = 1'b1;
				res.data_valid = 1'b1;
				res.data_byte = b;
				left = left - 1'b1;
				if (left == '0) begin
					line_phase = PH_SKIP;
					skip_cnt = '0;
				end
			end
			PH_SKIP: begin
				skip_cnt = skip_cnt + 1'b1;
				if (skip_cnt >= 2'd2) begin
					skip_cnt = '0;
					line_phase = PH_SIZE;
					new_line();
				end
			end
			default: begin
			end
		endcase
		if (it.end_of_body) begin
			if (!fin && line_phase != PH_DRAIN) begin
				emit = 1'b1;
				fin = 1'b1;
				why = ST_EARLY;
			end
			line_phase = PH_SIZE;
			left = '0;
			skip_cnt = '0;
			new_line();
		end
		res.last = fin;
		res.status = fin ? why : '0;
		return emit;
	endfunction

	function automatic void add_item(logic [7:0] b, logic eob);
		feed_row_t r;
		r = '0;
		r.it.body_byte = b;
		r.it.end_of_body = eob;
		body_feed.insert(body_feed.size(), r);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		body_bytes.insert(body_bytes.size(), b);
	endfunction

	function automatic void put_hex(logic [31:0] v, int unsigned ndig);
		logic [3:0] nib;
		for (int i = int'(ndig) - 1; i >= 0; i--) begin
			nib = v[4*i +: 4];
			if (nib < 10) put_byte(8'("0" + nib));
			else if ($urandom_range(0, 1) == 0) put_byte(8'("a" + nib - 10));
			else put_byte(8'("A" + nib - 10));
		end
	endfunction

	function automatic void put_line(logic [31:0] v);
		int unsigned ndig;
		int unsigned roll;
		ndig = 1;
		while (ndig < 8 && (v >> (4 * ndig)) != 0) ndig++;
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			put_byte(" ");
		end else if (roll < 3) begin
			put_byte("+");
		end else if (roll < 5) begin
			put_byte("0");
			put_byte("x");
		end
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_byte("0");
		put_hex(v, ndig);
		if ($urandom_range(0, 3) == 0) begin
			put_byte(";");
			repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(8'h20, 8'h7e)));
		end
		if ($urandom_range(0, 11) == 0) begin
			put_byte(CHAR_CR);
			put_byte("z");
		end
		put_byte(CHAR_CR);
		put_byte(CHAR_LF);
	endfunction

	function automatic void gen_body();
		int unsigned kind;
		int unsigned sz;
		int unsigned tail;
		int unsigned keep;
		int unsigned roll;
		body_bytes.delete();
		tail = 0;
		kind = $urandom_range(0, 99);
		if (kind < 7) begin
			repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
		end else if (kind < 13) begin
			put_hex($urandom(), 8);
			put_byte(CHAR_CR);
			put_byte(CHAR_LF);
			repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) begin
				roll = $urandom_range(0, 99);
				if (roll < 70) sz = $urandom_range(1, 8);
				else if (roll < 95) sz = $urandom_range(9, 40);
				else sz = $urandom_range(41, 300);
				put_line(sz);
				repeat (sz) put_byte(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) != 0) begin
					put_byte(CHAR_CR);
					put_byte(CHAR_LF);
				end else begin
					repeat (2) put_byte(8'($urandom_range(0, 255)));
				end
			end
			put_line(0);
			tail = $urandom_range(0, 3);
			repeat (tail) put_byte(8'($urandom_range(0, 255)));
			if (kind < 25) begin
				keep = $urandom_range(1, body_bytes.size());
				while (body_bytes.size() > keep) void'(body_bytes.pop_back());
				tail = 0;
			end
		end
		random_items += body_bytes.size() - tail;
		foreach (body_bytes[i]) add_item(body_bytes[i], i == body_bytes.size() - 1);
	endfunction

	function automatic int unsigned idle_pct(bit sender);
		case ((row_idx / 300) % 4)
			1: return sender ? 55 : 0;
			2: return sender ? 0 : 55;
			3: return 21;
			default: return 0;
		endcase
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender
	initial begin : feed
		feed_row_t r;
		out_item_t want;
		bit        emits;
		bit        offer;
		foreach (directed_rows[i]) begin
			r = '0;
			r.it.body_byte = directed_rows[i].b;
			r.it.end_of_body = directed_rows[i].eob;
			r.chk = directed_rows[i].chk;
			r.emits = directed_rows[i].emits;
			r.res.data_byte = directed_rows[i].data;
			r.res.data_valid = directed_rows[i].valid;
			r.res.last = directed_rows[i].last;
			r.res.status = directed_rows[i].status;
			body_feed.insert(body_feed.size(), r);
		end
		while (random_items < RANDOM_ITEMS) gen_body();
		body_feed[$size(directed_rows)].hold = 1'b1;
		body_feed[900].hold = 1'b1;
		wait (arst_n);
		while (row_idx < body_feed.size()) begin
			@(posedge clk);
			if (push && !full) begin
				r = body_feed[row_idx];
				emits = decode_step(r.it, want);
				if (r.chk) begin
					emits = r.emits;
					want = r.res;
				end
				if (emits) pending_results.insert(pending_results.size(), want);
				if (row_idx == 50 || row_idx == 1250) stall_req = 1'b1;
				row_idx++;
			end
			if (!(push && full)) begin
				if (row_idx >= body_feed.size()) begin
					push <= 1'b0;
				end else begin
					if (body_feed[row_idx].hold && pending_results.size() != 0) begin
						offer = 1'b0;
					end else begin
						body_feed[row_idx].hold = 1'b0;
						offer = $urandom_range(0, 99) >= idle_pct(1'b1);
					end
					push <= offer;
					item <= body_feed[row_idx].it;
				end
			end
		end
		feed_done = 1'b1;
	end

	// receiver
	initial begin : drain_side
		int unsigned hold_left;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= $urandom_range(0, 99) >= idle_pct(1'b0);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			result_count++;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("result %0d unexpected: data=%02h valid=%b last=%b status=%0d",
						result_count, result.data_byte, result.data_valid, result.last,
						result.status);
			end else begin
				want = pending_results.pop_front();
				if (result.data_byte !== want.data_byte || result.data_valid !== want.data_valid
						|| result.last !== want.last || result.status !== want.status) begin
					error_count++;
					if (error_count <= 10)
						$display({"result %0d: expected data=%02h valid=%b last=%b status=%0d",
							", got data=%02h valid=%b last=%b status=%0d"},
							result_count, want.data_byte, want.data_valid, want.last,
							want.status, result.data_byte, result.data_valid, result.last,
							result.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) quiet <= 0;
		else quiet <= quiet + 1;
	end

	initial begin : watchdog
		while (quiet < QUIET_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : finish_run
		wait (arst_n);
		while (!feed_done) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/hcbd_pkg.sv
hdl/hcbd_front.sv
hdl/hcbd_back.sv
hdl/http_chunked_body_decoder_top.sv
sim/testbench.sv
